### rtl/slcl_pkg.sv
// ----------------------------------------------------------------------------
// slcl_pkg: shared types and constants of the union-area sweep engine
// Operation codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package slcl_pkg;

  localparam int LEN_W   = 32;
  localparam int AREA_W  = 63;
  localparam int CFG_W   = 11;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
  localparam logic [CFG_W-1:0]  COORD_COUNT_RST = 11'd1024;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_EDGE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_INIT_CLR,
    S_IDLE,
    S_LOAD,
    S_CLR,
    S_MUL,
    S_ADD,
    S_VISIT,
    S_RET,
    S_R0,
    S_R1,
    S_R2,
    S_R3,
    S_DONE
  } state_t;

endpackage

### rtl/slcl_ram.sv
// ----------------------------------------------------------------------------
// slcl_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module slcl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/slcl_area_unit.sv
// ----------------------------------------------------------------------------
// slcl_area_unit: strip area multiply and saturating accumulate
// Registered 32x32 product, then a saturating add onto the running area.
// ----------------------------------------------------------------------------
module slcl_area_unit (
  input  logic                        clk,
  input  logic                        start,
  input  logic [31:0]                 dy,
  input  logic [slcl_pkg::LEN_W-1:0]  len,
  input  logic [slcl_pkg::AREA_W-1:0] area_in,
  output logic [slcl_pkg::AREA_W-1:0] area_out
);
  import slcl_pkg::*;

  logic [63:0]       prod;
  logic [AREA_W+1:0] sum;

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= 64'(dy) * 64'(len);
    end
  end

  // sum is 65 bits wide so the carry is kept; anything above the 63-bit limit saturates
  always_comb begin
    sum      = {2'b00, area_in} + {1'b0, prod};
    area_out = (sum > {2'b00, AREA_MAX}) ? AREA_MAX : sum[AREA_W-1:0];
  end

endmodule

### rtl/sweep_line_covered_length_area_unit.sv
// ----------------------------------------------------------------------------
// sweep_line_covered_length_area_unit: union-of-rectangles area sweep engine
// Coordinate table, non-propagating segment tree in RAM, saturating area.
// ----------------------------------------------------------------------------
// Edge: multiply and add steps, then, per tree node touched, a visit step and a
//   read-modify-write through S_R0 to S_R3, plus a return step.
// The single tree RAM port sequence sets the rate; one transaction at a time.
// Reset: synchronous; afterwards a clearing pass over all 4*NUM_COORDS tree entries
//   zeroes the tree RAM with in_ready low. Configuration writes are taken throughout.
module sweep_line_covered_length_area_unit #(
  parameter int NUM_COORDS  = 1024,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [slcl_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  operation,
  input  logic [9:0]                  coord_index,
  input  logic signed [31:0]          coord_value,
  input  logic [9:0]                  lo_index,
  input  logic [9:0]                  hi_index,
  input  logic signed [31:0]          edge_y,
  input  logic signed [1:0]           delta,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [slcl_pkg::LEN_W-1:0]  covered_length,
  output logic [slcl_pkg::AREA_W-1:0] area
);
  import slcl_pkg::*;

  // widths: coordinate address, index arithmetic, tree node, stack
  localparam int CW     = $clog2(NUM_COORDS);
  localparam int XW     = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int TREE_D = 4 * NUM_COORDS;
  localparam int NW     = $clog2(TREE_D);
  localparam int SD     = CW + 2;
  localparam int SPW    = $clog2(SD + 1);
  localparam int SIW    = $clog2(SD);
  localparam int TW     = COUNT_WIDTH + LEN_W;

  state_t state, state_next;

  // configuration
  logic [CFG_W-1:0] coord_count;

  // latched transaction
  logic [XW-1:0]          load_idx;
  logic [31:0]            load_val;
  logic [31:0]            y_r;
  logic [1:0]             d_r;
  logic [XW-1:0]          a_r, b_r;
  logic                   span_ok;

  // sweep state
  logic [AREA_W-1:0] area_acc;
  logic [31:0]       prev_y;
  logic              seen_edge;
  logic [LEN_W-1:0]  root_len;

  // tree walk
  logic [NW-1:0] cur_node;
  logic [XW-1:0] cur_l, cur_r;
  logic          add_en;
  logic [NW-1:0] stk_node [SD];
  logic [XW-1:0] stk_l    [SD];
  logic [XW-1:0] stk_r    [SD];
  logic          stk_ph   [SD];
  logic [SPW-1:0] sp;
  logic [NW-1:0]  clr_addr;

  // refresh registers
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [31:0]            cl_r, cr_r;
  logic [LEN_W-1:0]       lenl_r;

  // RAM ports
  logic          ct_we;
  logic [CW-1:0] ct_waddr, ct_raddr;
  logic [31:0]   ct_rdata;
  logic          tr_we;
  logic [NW-1:0] tr_waddr, tr_raddr;
  logic [TW-1:0] tr_wdata, tr_rdata;

  // area unit
  logic              au_start;
  logic [31:0]       au_dy;
  logic [AREA_W-1:0] au_area;

  // combinational helpers
  logic              accept;
  logic [XW-1:0]     cc_e, n_leaves, hi_e, hi_c, lo_e;
  logic [XW:0]       m_sum, tm_sum;
  logic [XW-1:0]     m, tm;
  logic [SIW-1:0]    top;
  logic              full;
  logic              gain;
  logic [NW-1:0]     left_child, right_child, t_right;
  logic [LEN_W-1:0]  new_len;
  logic              cnt_pos;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);

  // leaf count from the clamped coordinate count
  always_comb begin
    cc_e = XW'(coord_count);
    if (cc_e < XW'(2)) begin
      cc_e = XW'(2);
    end else if (cc_e > XW'(NUM_COORDS)) begin
      cc_e = XW'(NUM_COORDS);
    end
    n_leaves = cc_e - XW'(1);
    hi_e     = {{(XW-10){1'b0}}, hi_index};
    lo_e     = {{(XW-10){1'b0}}, lo_index};
    hi_c     = (hi_e > n_leaves) ? n_leaves : hi_e;
  end

  // walk geometry
  always_comb begin
    top         = SIW'(sp - SPW'(1));
    m_sum       = {1'b0, cur_l} + {1'b0, cur_r};
    m           = m_sum[XW:1];
    tm_sum      = {1'b0, stk_l[top]} + {1'b0, stk_r[top]};
    tm          = tm_sum[XW:1];
    full        = (a_r <= cur_l) && (cur_r <= b_r);
    left_child  = {cur_node[NW-2:0], 1'b0};
    right_child = {cur_node[NW-2:0], 1'b1};
    t_right     = {stk_node[top][NW-2:0], 1'b1};
  end

  // node length: full span when count positive, leaf zero, else child sum
  always_comb begin
    cnt_pos = (cnt_r != '0) && !cnt_r[COUNT_WIDTH-1];
    if (cnt_pos) begin
      new_len = cr_r - cl_r;
    end else if (cur_l == cur_r) begin
      new_len = '0;
    end else begin
      new_len = lenl_r + tr_rdata[LEN_W-1:0];
    end
  end

  assign gain  = seen_edge && ($signed(y_r) > $signed(prev_y));
  assign au_dy = gain ? (y_r - prev_y) : 32'd0;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT_CLR: begin
        if (clr_addr == NW'(TREE_D - 1)) state_next = S_IDLE;
      end
      S_CLR: begin
        if (clr_addr == NW'(TREE_D - 1)) state_next = S_DONE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(operation))
            OP_LOAD:  state_next = S_LOAD;
            OP_CLEAR: state_next = S_CLR;
            OP_EDGE:  state_next = S_MUL;
            OP_NONE:  state_next = S_DONE;
          endcase
        end
      end
      S_LOAD:  state_next = S_DONE;
      S_MUL:   state_next = S_ADD;
      S_ADD:   state_next = span_ok ? S_VISIT : S_DONE;
      S_VISIT: state_next = full ? S_R0 : S_VISIT;
      S_RET: begin
        if (sp == '0) begin
          state_next = S_DONE;
        end else if (!stk_ph[top] && (b_r > tm)) begin
          state_next = S_VISIT;
        end else begin
          state_next = S_R0;
        end
      end
      S_R0: state_next = S_R1;
      S_R1: state_next = S_R2;
      S_R2: state_next = S_R3;
      S_R3: state_next = S_RET;
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // RAM and unit controls
  always_comb begin
    ct_we    = 1'b0;
    ct_waddr = load_idx[CW-1:0];
    ct_raddr = cur_l[CW-1:0];
    tr_we    = 1'b0;
    tr_waddr = cur_node;
    tr_wdata = {cnt_r, new_len};
    tr_raddr = cur_node;
    au_start = 1'b0;
    unique case (state)
      S_INIT_CLR, S_CLR: begin
        tr_we    = 1'b1;
        tr_waddr = clr_addr;
        tr_wdata = '0;
      end
      S_LOAD: ct_we = (load_idx < XW'(NUM_COORDS));
      S_MUL:  au_start = 1'b1;
      S_R1: begin
        tr_raddr = left_child;
        ct_raddr = CW'(cur_r + XW'(1));
      end
      S_R2: tr_raddr = right_child;
      S_R3: tr_we = 1'b1;
      default: ;
    endcase
  end

  slcl_ram #(.WIDTH(32), .DEPTH(NUM_COORDS)) u_coord_ram (
    .clk   (clk),
    .we    (ct_we),
    .waddr (ct_waddr),
    .wdata (load_val),
    .raddr (ct_raddr),
    .rdata (ct_rdata)
  );

  slcl_ram #(.WIDTH(TW), .DEPTH(TREE_D)) u_tree_ram (
    .clk   (clk),
    .we    (tr_we),
    .waddr (tr_waddr),
    .wdata (tr_wdata),
    .raddr (tr_raddr),
    .rdata (tr_rdata)
  );

  slcl_area_unit u_area (
    .clk      (clk),
    .start    (au_start),
    .dy       (au_dy),
    .len      (root_len),
    .area_in  (area_acc),
    .area_out (au_area)
  );

  // configuration register: taken at any time
  always_ff @(posedge clk) begin
    if (rst) begin
      coord_count <= COORD_COUNT_RST;
    end else if (cfg_we) begin
      coord_count <= cfg_wdata;
    end
  end

  // control and sweep state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT_CLR;
      clr_addr  <= '0;
      sp        <= '0;
      area_acc  <= '0;
      prev_y    <= '0;
      seen_edge <= 1'b0;
      root_len  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // result slot: filled from DONE once free, emptied by the handshake
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT_CLR, S_CLR: begin
          clr_addr <= (clr_addr == NW'(TREE_D - 1)) ? '0 : clr_addr + NW'(1);
        end
        S_IDLE: begin
          if (accept && (op_t'(operation) == OP_CLEAR)) begin
            area_acc  <= '0;
            prev_y    <= '0;
            seen_edge <= 1'b0;
            root_len  <= '0;
          end
        end
        S_ADD: begin
          area_acc  <= au_area;
          prev_y    <= y_r;
          seen_edge <= 1'b1;
          sp        <= '0;
        end
        S_VISIT: begin
          if (!full) begin
            stk_node[sp[SIW-1:0]] <= cur_node;
            stk_l[sp[SIW-1:0]]    <= cur_l;
            stk_r[sp[SIW-1:0]]    <= cur_r;
            stk_ph[sp[SIW-1:0]]   <= !(a_r <= m);
            sp <= sp + SPW'(1);
          end
        end
        S_RET: begin
          if (sp != '0) begin
            if (!stk_ph[top] && (b_r > tm)) begin
              stk_ph[top] <= 1'b1;
            end else begin
              sp <= sp - SPW'(1);
            end
          end
        end
        S_R3: begin
          if (cur_node == NW'(1)) root_len <= new_len;
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      load_idx <= {{(XW-10){1'b0}}, coord_index};
      load_val <= coord_value;
      y_r      <= edge_y;
      d_r      <= delta;
      a_r      <= lo_e;
      b_r      <= hi_c - XW'(1);
      span_ok  <= (lo_e < hi_c);
      add_en   <= 1'b1;
    end
    unique case (state)
      S_ADD: begin
        cur_node <= NW'(1);
        cur_l    <= '0;
        cur_r    <= n_leaves - XW'(1);
        add_en   <= 1'b1;
      end
      S_VISIT: begin
        if (!full) begin
          if (a_r <= m) begin
            cur_node <= left_child;
            cur_r    <= m;
          end else begin
            cur_node <= right_child;
            cur_l    <= m + XW'(1);
          end
        end
      end
      S_RET: begin
        if (sp != '0) begin
          if (!stk_ph[top] && (b_r > tm)) begin
            cur_node <= t_right;
            cur_l    <= tm + XW'(1);
            cur_r    <= stk_r[top];
            add_en   <= 1'b1;
          end else begin
            cur_node <= stk_node[top];
            cur_l    <= stk_l[top];
            cur_r    <= stk_r[top];
            add_en   <= 1'b0;
          end
        end
      end
      S_R1: begin
        cnt_r <= tr_rdata[TW-1:LEN_W] +
                 (add_en ? {{(COUNT_WIDTH-2){d_r[1]}}, d_r} : '0);
        cl_r  <= ct_rdata;
      end
      S_R2: begin
        cr_r   <= ct_rdata;
        lenl_r <= tr_rdata[LEN_W-1:0];
      end
      S_R3: add_en <= 1'b1;
      default: ;
    endcase
    if ((state == S_DONE) && (!out_valid || out_ready)) begin
      covered_length <= root_len;
      area           <= area_acc;
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst) sp <= SPW'(SD))
    else $error("walk stack overflow");

  assert property (@(posedge clk) disable iff (rst) in_ready |-> (sp == '0 || !span_ok))
    else $error("idle with a walk still stacked");

  assert property (@(posedge clk) disable iff (rst)
    !(accept && (op_t'(operation) == OP_CLEAR)) |=> area_acc >= $past(area_acc))
    else $error("area fell without a clear");

endmodule
